// File: sv/drg_pkg.sv
// Shared constants, codes and helper functions for the drive reversal gate.
// Used by drive_reversal_gate_top; depends on nothing else.
package drg_pkg;

  // Field and counter widths.
  localparam int VEL_W  = 16;
  localparam int TMR_W  = 16;
  localparam int KIND_W = 2;
  localparam int THR_W  = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [TMR_W-1:0] TMR_MAX = {TMR_W{1'b1}};

  // Input item kinds.
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CMD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STOP = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] RES_DRIVE    = 2'd0;
  localparam logic [KIND_W-1:0] RES_CMD_ACK  = 2'd1;
  localparam logic [KIND_W-1:0] RES_STOP_ACK = 2'd2;

  // Direction codes of the linear velocity.
  localparam logic [1:0] SIGN_ZERO = 2'd0;
  localparam logic [1:0] SIGN_POS  = 2'd1;
  localparam logic [1:0] SIGN_NEG  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STILL_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REV_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_TMO   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 2'd3;

  // Register values after reset.
  localparam logic [THR_W-1:0] STILL_THR_RST = 15'd20;
  localparam logic [TMR_W-1:0] REV_LIMIT_RST = 16'd1000;
  localparam logic [TMR_W-1:0] CMD_TMO_RST   = 16'd500;
  localparam logic [THR_W-1:0] DEADBAND_RST  = 15'd100;

  // Direction of a velocity, with values inside the deadband counting as zero.
  function automatic logic [1:0] sign_of(input logic [VEL_W-1:0] v,
                                         input logic [THR_W-1:0] db);
    logic signed [VEL_W:0] vx;
    logic signed [VEL_W:0] dx;
    logic [1:0] s;
    vx = {v[VEL_W-1], v};
    dx = {{(VEL_W+1-THR_W){1'b0}}, db};
    if (vx > dx) begin
      s = SIGN_POS;
    end else if (vx < -dx) begin
      s = SIGN_NEG;
    end else begin
      s = SIGN_ZERO;
    end
    return s;
  endfunction

  // Magnitude of a signed value, one bit wider so the most negative value fits.
  function automatic logic [VEL_W:0] mag(input logic [VEL_W-1:0] v);
    logic [VEL_W:0] vx;
    vx = {v[VEL_W-1], v};
    return v[VEL_W-1] ? (~vx + 1'b1) : vx;
  endfunction

  // Saturating increment of an elapsed-time counter.
  function automatic logic [TMR_W-1:0] sat_inc(input logic [TMR_W-1:0] c);
    return (c == TMR_MAX) ? c : c + 1'b1;
  endfunction

endpackage

// File: sv/drive_reversal_gate_top.sv
// Drive reversal gate: holds drive commands that reverse direction until the
// wheels are still. Depends on drg_pkg for widths, codes and helpers.
//
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+-------------------------------
//  s_axis   | in        | s_axis_tvalid/tready    | tuser: kind; tdata: velocities,
//           |           |                         |   wheel speeds
//  m_axis   | out       | m_axis_tvalid/tready    | tuser: result_kind; tdata: drive
//  cfg      | in        | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// An accepted item lands in an input register; once the output register is free
// or being taken it is evaluated against the gate state and its result, if any,
// is loaded into the output register. One item can be taken every cycle while
// the output is not stalled. A stalled output only stops the input register from
// draining; the input register frees itself in the same cycle the output is
// taken. Synchronous reset clears the gate state and loads the register defaults.
module drive_reversal_gate_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // linear_velocity, angular_velocity,
                                     // speed_left, speed_right
  input  logic [1:0]  s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // drive_linear, drive_angular
  output logic [1:0]  m_axis_tuser,  // result_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int VW = drg_pkg::VEL_W;
  localparam int TW = drg_pkg::TMR_W;
  localparam int HW = drg_pkg::THR_W;

  // Configuration registers.
  logic [HW-1:0] still_threshold;
  logic [TW-1:0] reversal_limit_ms;
  logic [TW-1:0] command_timeout_ms;
  logic [HW-1:0] sign_deadband;

  // Input register.
  logic          in_valid;
  logic [1:0]    in_kind;
  logic [VW-1:0] in_lin;
  logic [VW-1:0] in_ang;
  logic [VW-1:0] in_left;
  logic [VW-1:0] in_right;

  // Gate state.
  logic          reversal_waiting, reversal_waiting_next;
  logic [VW-1:0] held_linear, held_linear_next;
  logic [VW-1:0] held_angular, held_angular_next;
  logic          queued_valid, queued_valid_next;
  logic [VW-1:0] queued_linear, queued_linear_next;
  logic [VW-1:0] queued_angular, queued_angular_next;
  logic [1:0]    released_sign, released_sign_next;
  logic [TW-1:0] reversal_elapsed, reversal_elapsed_next;
  logic [TW-1:0] command_elapsed, command_elapsed_next;
  logic          timeout_armed, timeout_armed_next;

  // Output register.
  logic          out_valid;
  logic [1:0]    out_kind;
  logic [VW-1:0] out_lin;
  logic [VW-1:0] out_ang;

  // Evaluation results.
  logic          res_valid;
  logic [1:0]    res_kind;
  logic [VW-1:0] res_lin;
  logic [VW-1:0] res_ang;
  logic          process;
  logic [TW-1:0] rev_inc;
  logic [TW-1:0] cmd_inc;
  logic          still;
  logic          expired;
  logic [1:0]    cmd_sign;
  logic          reversal;

  // The input register drains whenever the output slot is free or being taken.
  assign process       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || process;
  assign cfg_ready     = 1'b1;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {out_ang, out_lin};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      still_threshold    <= drg_pkg::STILL_THR_RST;
      reversal_limit_ms  <= drg_pkg::REV_LIMIT_RST;
      command_timeout_ms <= drg_pkg::CMD_TMO_RST;
      sign_deadband      <= drg_pkg::DEADBAND_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        drg_pkg::REG_STILL_THR: still_threshold    <= cfg_data[HW-1:0];
        drg_pkg::REG_REV_LIMIT: reversal_limit_ms  <= cfg_data[TW-1:0];
        drg_pkg::REG_CMD_TMO:   command_timeout_ms <= cfg_data[TW-1:0];
        drg_pkg::REG_DEADBAND:  sign_deadband      <= cfg_data[HW-1:0];
        default: ;
      endcase
    end
  end

  // Input register load on each accepted transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_kind  <= s_axis_tuser;
      in_lin   <= s_axis_tdata[VW-1:0];
      in_ang   <= s_axis_tdata[2*VW-1:VW];
      in_left  <= s_axis_tdata[3*VW-1:2*VW];
      in_right <= s_axis_tdata[4*VW-1:3*VW];
    end
  end

  // Shared terms of the evaluation.
  assign rev_inc  = drg_pkg::sat_inc(reversal_elapsed);
  assign cmd_inc  = drg_pkg::sat_inc(command_elapsed);
  assign still    = (drg_pkg::mag(in_left) < {{(VW+1-HW){1'b0}}, still_threshold}) &&
                    (drg_pkg::mag(in_right) < {{(VW+1-HW){1'b0}}, still_threshold});
  assign expired  = rev_inc > reversal_limit_ms;
  assign cmd_sign = drg_pkg::sign_of(in_lin, sign_deadband);
  assign reversal = (released_sign == drg_pkg::SIGN_POS && cmd_sign == drg_pkg::SIGN_NEG) ||
                    (released_sign == drg_pkg::SIGN_NEG && cmd_sign == drg_pkg::SIGN_POS);

  // Evaluate the item in the input register against the gate state.
  always_comb begin
    reversal_waiting_next = reversal_waiting;
    held_linear_next      = held_linear;
    held_angular_next     = held_angular;
    queued_valid_next     = queued_valid;
    queued_linear_next    = queued_linear;
    queued_angular_next   = queued_angular;
    released_sign_next    = released_sign;
    reversal_elapsed_next = reversal_elapsed;
    command_elapsed_next  = command_elapsed;
    timeout_armed_next    = timeout_armed;
    res_valid             = 1'b0;
    res_kind              = drg_pkg::RES_DRIVE;
    res_lin               = '0;
    res_ang               = '0;
    case (in_kind)
      drg_pkg::KIND_TICK: begin
        reversal_elapsed_next = rev_inc;
        command_elapsed_next  = cmd_inc;
        if (reversal_waiting) begin
          // While a reversal waits, output zero until the wheels stop or time runs out.
          res_valid = 1'b1;
          if (still || expired) begin
            reversal_waiting_next = 1'b0;
            queued_valid_next     = 1'b0;
            command_elapsed_next  = '0;
            timeout_armed_next    = 1'b1;
            released_sign_next    = drg_pkg::sign_of(held_linear, sign_deadband);
            res_lin               = held_linear;
            res_ang               = held_angular;
          end
        end else if (queued_valid) begin
          queued_valid_next = 1'b0;
          res_valid         = 1'b1;
          res_lin           = queued_linear;
          res_ang           = queued_angular;
        end else if (timeout_armed && cmd_inc > command_timeout_ms) begin
          timeout_armed_next = 1'b0;
          res_valid          = 1'b1;
        end
      end
      drg_pkg::KIND_CMD: begin
        if (reversal) begin
          held_linear_next      = in_lin;
          held_angular_next     = in_ang;
          reversal_waiting_next = 1'b1;
          reversal_elapsed_next = '0;
          queued_linear_next    = '0;
          queued_angular_next   = '0;
        end else begin
          queued_linear_next  = in_lin;
          queued_angular_next = in_ang;
          released_sign_next  = cmd_sign;
        end
        queued_valid_next    = 1'b1;
        command_elapsed_next = '0;
        timeout_armed_next   = 1'b1;
        res_valid            = 1'b1;
        res_kind             = drg_pkg::RES_CMD_ACK;
        res_lin              = in_lin;
        res_ang              = in_ang;
      end
      drg_pkg::KIND_STOP: begin
        queued_linear_next    = '0;
        queued_angular_next   = '0;
        queued_valid_next     = 1'b1;
        reversal_waiting_next = 1'b0;
        released_sign_next    = drg_pkg::SIGN_ZERO;
        command_elapsed_next  = '0;
        timeout_armed_next    = 1'b1;
        res_valid             = 1'b1;
        res_kind              = drg_pkg::RES_STOP_ACK;
      end
      default: ;
    endcase
  end

  // Gate state update when an item is evaluated.
  always_ff @(posedge clk) begin
    if (rst) begin
      reversal_waiting <= 1'b0;
      held_linear      <= '0;
      held_angular     <= '0;
      queued_valid     <= 1'b0;
      queued_linear    <= '0;
      queued_angular   <= '0;
      released_sign    <= drg_pkg::SIGN_ZERO;
      reversal_elapsed <= '0;
      command_elapsed  <= '0;
      timeout_armed    <= 1'b0;
    end else if (process) begin
      reversal_waiting <= reversal_waiting_next;
      held_linear      <= held_linear_next;
      held_angular     <= held_angular_next;
      queued_valid     <= queued_valid_next;
      queued_linear    <= queued_linear_next;
      queued_angular   <= queued_angular_next;
      released_sign    <= released_sign_next;
      reversal_elapsed <= reversal_elapsed_next;
      command_elapsed  <= command_elapsed_next;
      timeout_armed    <= timeout_armed_next;
    end
  end

  // Output register: loads a result, or empties once its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process) begin
      out_valid <= res_valid;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (process && res_valid) begin
      out_kind <= res_kind;
      out_lin  <= res_lin;
      out_ang  <= res_ang;
    end
  end

endmodule

// File: bench/tb_drive_reversal_gate_top.sv
// Self-checking testbench for drive_reversal_gate_top: drives command, tick and stop items,
// predicts every result in a scoreboard and compares it field by field.
// Depends on drg_pkg and drive_reversal_gate_top.
module tb_drive_reversal_gate_top;

  // An item kind that the gate ignores.
  localparam logic [drg_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_LIMIT    = 4000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int MAX_LIMIT_TICKS = 16;

  // Scoreboard: mirrors the gate state and holds the results still to come.
  class drive_gate_sb;
    logic [drg_pkg::THR_W-1:0] still_thr;
    logic [drg_pkg::TMR_W-1:0] rev_limit;
    logic [drg_pkg::TMR_W-1:0] cmd_tmo;
    logic [drg_pkg::THR_W-1:0] deadband;

    logic                      waiting;
    logic [drg_pkg::VEL_W-1:0] held_lin;
    logic [drg_pkg::VEL_W-1:0] held_ang;
    logic                      queued;
    logic [drg_pkg::VEL_W-1:0] queued_lin;
    logic [drg_pkg::VEL_W-1:0] queued_ang;
    logic [1:0]                released_dir;
    logic [drg_pkg::TMR_W-1:0] rev_elapsed;
    logic [drg_pkg::TMR_W-1:0] cmd_elapsed;
    logic                      tmo_armed;

    logic [drg_pkg::KIND_W-1:0] exp_kind[$];
    logic [drg_pkg::VEL_W-1:0]  exp_lin[$];
    logic [drg_pkg::VEL_W-1:0]  exp_ang[$];
    int mismatches;

    function new();
      mismatches   = 0;
      still_thr    = drg_pkg::STILL_THR_RST;
      rev_limit    = drg_pkg::REV_LIMIT_RST;
      cmd_tmo      = drg_pkg::CMD_TMO_RST;
      deadband     = drg_pkg::DEADBAND_RST;
      waiting      = 1'b0;
      held_lin     = '0;
      held_ang     = '0;
      queued       = 1'b0;
      queued_lin   = '0;
      queued_ang   = '0;
      released_dir = drg_pkg::SIGN_ZERO;
      rev_elapsed  = '0;
      cmd_elapsed  = '0;
      tmo_armed    = 1'b0;
    endfunction

    // Direction of a linear velocity, with the deadband counting as no direction.
    function logic [1:0] direction(input logic [drg_pkg::VEL_W-1:0] v);
      logic signed [drg_pkg::VEL_W+1:0] vx;
      logic signed [drg_pkg::VEL_W+1:0] dx;
      vx = $signed({{2{v[drg_pkg::VEL_W-1]}}, v});
      dx = $signed({3'b000, deadband});
      if (vx > dx) return drg_pkg::SIGN_POS;
      if (vx < -dx) return drg_pkg::SIGN_NEG;
      return drg_pkg::SIGN_ZERO;
    endfunction

    // A wheel is still when its speed magnitude is below the threshold.
    function logic is_still(input logic [drg_pkg::VEL_W-1:0] s);
      logic [drg_pkg::VEL_W:0] m;
      m = s[drg_pkg::VEL_W-1] ? ({1'b0, ~s} + 1'b1) : {1'b0, s};
      return m < {2'b00, still_thr};
    endfunction

    function void push_result(input logic [drg_pkg::KIND_W-1:0] k,
                              input logic [drg_pkg::VEL_W-1:0] l,
                              input logic [drg_pkg::VEL_W-1:0] a);
      exp_kind.push_back(k);
      exp_lin.push_back(l);
      exp_ang.push_back(a);
    endfunction

    function int pending();
      return exp_kind.size();
    endfunction

    function void write_reg(input logic [drg_pkg::CFG_IDX_W-1:0] idx,
                            input logic [drg_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        drg_pkg::REG_STILL_THR: still_thr = d[drg_pkg::THR_W-1:0];
        drg_pkg::REG_REV_LIMIT: rev_limit = d;
        drg_pkg::REG_CMD_TMO:   cmd_tmo   = d;
        drg_pkg::REG_DEADBAND:  deadband  = d[drg_pkg::THR_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the gate state by one accepted input transfer.
    function void note_item(input logic [drg_pkg::KIND_W-1:0] kind,
                            input logic [drg_pkg::VEL_W-1:0] lin,
                            input logic [drg_pkg::VEL_W-1:0] ang,
                            input logic [drg_pkg::VEL_W-1:0] sl,
                            input logic [drg_pkg::VEL_W-1:0] sr);
      logic [1:0] new_dir;
      case (kind)
        drg_pkg::KIND_TICK: begin
          // Both timers move before any decision is made.
          if (rev_elapsed != drg_pkg::TMR_MAX) rev_elapsed = rev_elapsed + 1'b1;
          if (cmd_elapsed != drg_pkg::TMR_MAX) cmd_elapsed = cmd_elapsed + 1'b1;
          if (waiting) begin
            if ((is_still(sl) && is_still(sr)) || (rev_elapsed > rev_limit)) begin
              waiting      = 1'b0;
              queued       = 1'b0;
              cmd_elapsed  = '0;
              tmo_armed    = 1'b1;
              released_dir = direction(held_lin);
              push_result(drg_pkg::RES_DRIVE, held_lin, held_ang);
            end else begin
              push_result(drg_pkg::RES_DRIVE, '0, '0);
            end
          end else if (queued) begin
            queued = 1'b0;
            push_result(drg_pkg::RES_DRIVE, queued_lin, queued_ang);
          end else if (tmo_armed && (cmd_elapsed > cmd_tmo)) begin
            tmo_armed = 1'b0;
            push_result(drg_pkg::RES_DRIVE, '0, '0);
          end
        end
        drg_pkg::KIND_CMD: begin
          new_dir = direction(lin);
          if ((released_dir == drg_pkg::SIGN_POS && new_dir == drg_pkg::SIGN_NEG) ||
              (released_dir == drg_pkg::SIGN_NEG && new_dir == drg_pkg::SIGN_POS)) begin
            // A reversal is held until the wheels settle or the wait runs out.
            held_lin    = lin;
            held_ang    = ang;
            waiting     = 1'b1;
            rev_elapsed = '0;
            queued_lin  = '0;
            queued_ang  = '0;
          end else begin
            queued_lin   = lin;
            queued_ang   = ang;
            released_dir = new_dir;
          end
          queued      = 1'b1;
          cmd_elapsed = '0;
          tmo_armed   = 1'b1;
          push_result(drg_pkg::RES_CMD_ACK, lin, ang);
        end
        drg_pkg::KIND_STOP: begin
          queued_lin   = '0;
          queued_ang   = '0;
          queued       = 1'b1;
          waiting      = 1'b0;
          released_dir = drg_pkg::SIGN_ZERO;
          cmd_elapsed  = '0;
          tmo_armed    = 1'b1;
          push_result(drg_pkg::RES_STOP_ACK, '0, '0);
        end
        default: ;
      endcase
    endfunction

    task report(input string msg);
      if (mismatches < 50) $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // Compare one accepted output transfer with the oldest expected result.
    task check_drive(input logic [drg_pkg::KIND_W-1:0] k,
                     input logic [drg_pkg::VEL_W-1:0] l,
                     input logic [drg_pkg::VEL_W-1:0] a);
      logic [drg_pkg::KIND_W-1:0] wk;
      logic [drg_pkg::VEL_W-1:0]  wl;
      logic [drg_pkg::VEL_W-1:0]  wa;
      if (exp_kind.size() == 0) begin
        report($sformatf("unexpected result kind %0d linear %0d angular %0d",
                         k, $signed(l), $signed(a)));
        return;
      end
      wk = exp_kind.pop_front();
      wl = exp_lin.pop_front();
      wa = exp_ang.pop_front();
      if (k != wk) report($sformatf("result_kind got %0d want %0d", k, wk));
      if (l != wl) report($sformatf("drive_linear got %0d want %0d", $signed(l), $signed(wl)));
      if (a != wa) report($sformatf("drive_angular got %0d want %0d", $signed(a), $signed(wa)));
    endtask

    task drop_leftovers();
      logic [drg_pkg::KIND_W-1:0] wk;
      while (exp_kind.size() > 0) begin
        wk = exp_kind.pop_front();
        void'(exp_lin.pop_front());
        void'(exp_ang.pop_front());
        report($sformatf("result of kind %0d never arrived", wk));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  drive_gate_sb sb = new();
  int   items_sent = 0;
  bit   fast_mode = 1'b0;
  bit   rx_holding = 1'b0;
  event rx_hold_go;

  drive_reversal_gate_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #8000000;
    $display("tb_drive_reversal_gate_top failed");
    $finish;
  end

  // Monitor: every transfer on the three channels is seen at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_drive(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16]);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_item(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                     s_axis_tdata[47:32], s_axis_tdata[63:48]);
      if (cfg_valid && cfg_ready)
        sb.write_reg(cfg_index, cfg_data);
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering meanwhile.
  initial begin
    forever begin
      @(rx_hold_go);
      rx_holding = 1'b1;
      repeat (RX_HOLD_CYCLES) @(negedge clk);
      rx_holding = 1'b0;
    end
  end

  // Receiver: random stalls, mostly short, a few long.
  initial begin : rx_stalls
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rx_holding) begin
        m_axis_tready <= 1'b0;
      end else if (fast_mode) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 9) < 6) begin
        m_axis_tready <= 1'b1;
      end else begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (fast_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [1:0] flip_dir(input logic [1:0] d);
    return (d == drg_pkg::SIGN_POS) ? drg_pkg::SIGN_NEG : drg_pkg::SIGN_POS;
  endfunction

  // Linear velocity of a wanted direction, leaning on the deadband edges.
  function automatic logic [15:0] rand_lin(input logic [1:0] d);
    int db;
    int v;
    db = sb.deadband;
    if (d == drg_pkg::SIGN_POS) begin
      if (db >= 32767) v = 32767;
      else case ($urandom_range(0, 3))
        0: v = db + 1;
        1: v = 32767;
        default: v = $urandom_range(db + 1, 32767);
      endcase
    end else if (d == drg_pkg::SIGN_NEG) begin
      case ($urandom_range(0, 3))
        0: v = -(db + 1);
        1: v = -32768;
        default: v = -int'($urandom_range(db + 1, 32768));
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0: v = db;
        1: v = -db;
        default: v = int'($urandom_range(0, 2 * db)) - db;
      endcase
    end
    return v[15:0];
  endfunction

  // Wheel speed either below the stillness threshold or at or above it.
  function automatic logic [15:0] rand_speed(input bit want_still);
    int t;
    int v;
    t = sb.still_thr;
    if (want_still && t > 0) begin
      v = int'($urandom_range(0, 2 * t - 2)) - (t - 1);
    end else begin
      case ($urandom_range(0, 3))
        0: v = $urandom_range(0, 1) ? t : -t;
        1: v = $urandom_range(0, 1) ? 32767 : -32768;
        default: v = $urandom();
      endcase
    end
    return v[15:0];
  endfunction

  // Offer one item on the input channel and wait for its transfer.
  task automatic send_item(input logic [1:0] kind, input logic [15:0] lin,
                           input logic [15:0] ang, input logic [15:0] sl,
                           input logic [15:0] sr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {sr, sl, ang, lin};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  task automatic send_tick(input bit left_still, input bit right_still);
    send_item(drg_pkg::KIND_TICK, 16'($urandom()), 16'($urandom()),
              rand_speed(left_still), rand_speed(right_still));
  endtask

  task automatic send_cmd(input logic [15:0] lin);
    send_item(drg_pkg::KIND_CMD, lin, 16'($urandom()), 16'($urandom()), 16'($urandom()));
  endtask

  // Stop offering and let every expected result arrive, then let the pipe settle.
  task automatic wait_drained();
    int guard;
    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (sb.pending() > 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    if (sb.pending() > 0) sb.drop_leftovers();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all four registers; only called while the gate is drained.
  task automatic set_config(input logic [14:0] still, input logic [15:0] rev,
                            input logic [15:0] tmo, input logic [14:0] db);
    logic [1:0]  regs [4];
    logic [15:0] vals [4];
    regs = '{drg_pkg::REG_STILL_THR, drg_pkg::REG_REV_LIMIT,
             drg_pkg::REG_CMD_TMO, drg_pkg::REG_DEADBAND};
    vals = '{{1'b0, still}, rev, tmo, {1'b0, db}};
    for (int i = 0; i < 4; i++) begin
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Random traffic, reversal scenarios the most common kind, with random content.
  task automatic run_random(input int count);
    int target;
    int n;
    int cap;
    logic [1:0] d;
    target = items_sent + count;
    while (items_sent < target) begin
      fast_mode = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // Establish a direction, reverse it, then wait it out with assorted events.
          d = $urandom_range(0, 1) ? drg_pkg::SIGN_POS : drg_pkg::SIGN_NEG;
          send_cmd(rand_lin(d));
          if ($urandom_range(0, 1)) send_tick(1'b0, 1'b0);
          send_cmd(rand_lin(flip_dir(d)));
          cap = (int'(sb.rev_limit) + 2 < 40) ? int'(sb.rev_limit) + 2 : 40;
          n = $urandom_range(1, cap);
          for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
              0: send_cmd(rand_lin($urandom_range(0, 1) ? d : drg_pkg::SIGN_ZERO));
              1: send_cmd(rand_lin(flip_dir(d)));
              2: begin
                if ($urandom_range(0, 3) == 0)
                  send_item(drg_pkg::KIND_STOP, 16'($urandom()), 16'($urandom()),
                            16'($urandom()), 16'($urandom()));
                else
                  send_tick(1'b1, 1'b0);
              end
              default: begin
                if ($urandom_range(0, 5) == 0) send_tick(1'b1, 1'b1);
                else send_tick(1'($urandom_range(0, 1)), 1'b0);
              end
            endcase
          end
        end
        4, 5: begin
          send_cmd(rand_lin(drg_pkg::SIGN_ZERO + 2'($urandom_range(0, 2))));
          repeat ($urandom_range(1, 3))
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        6: begin
          send_item(drg_pkg::KIND_STOP, 16'($urandom()), 16'($urandom()),
                    16'($urandom()), 16'($urandom()));
          repeat ($urandom_range(1, 4))
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        7: begin
          // Now and then a command, then ticks, enough for the command timeout to fire when it is small.
          if ($urandom_range(0, 1)) send_cmd(16'($urandom()));
          n = (int'(sb.cmd_tmo) + 2 < 40) ? int'(sb.cmd_tmo) + 2 : 40;
          repeat (n) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        default: begin
          // Noise: any kind with random fields, now and then the ignored kind.
          repeat ($urandom_range(1, 6)) begin
            send_item(($urandom_range(0, 19) == 0) ? KIND_UNUSED : 2'($urandom_range(0, 2)),
                      16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
          end
        end
      endcase
    end
    fast_mode = 1'b0;
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings.
    send_item(drg_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(KIND_UNUSED, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
    send_item(drg_pkg::KIND_CMD, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
    send_item(drg_pkg::KIND_TICK, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000);
    send_item(drg_pkg::KIND_CMD, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000);
    send_item(drg_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h8000, 16'h0000);
    // A non-reversing command during the wait is dropped by the release.
    send_item(drg_pkg::KIND_CMD, 16'd50, 16'd5, 16'h0000, 16'h0000);
    send_item(drg_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'(19), 16'(-19));
    send_item(drg_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(drg_pkg::KIND_CMD, 16'd101, 16'(-7), 16'h0000, 16'h0000);
    send_item(drg_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'd20, 16'h0000);
    // A second reversal replaces the held command.
    send_item(drg_pkg::KIND_CMD, 16'd2000, 16'd300, 16'h0000, 16'h0000);
    send_item(drg_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 16'(-20));
    send_item(drg_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'(-19), 16'h0000);
    send_item(drg_pkg::KIND_CMD, 16'(-100), 16'd1, 16'h0000, 16'h0000);
    send_item(drg_pkg::KIND_CMD, 16'(-101), 16'd2, 16'h0000, 16'h0000);
    send_item(drg_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF);
    // A stop cancels a pending reversal and queues zero drive.
    send_item(drg_pkg::KIND_CMD, 16'd500, 16'h0000, 16'h0000, 16'h0000);
    send_item(drg_pkg::KIND_STOP, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
    send_item(drg_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
    send_item(drg_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    wait_drained();

    // Random phases over several register settings, extremes included.
    set_config(15'd20, 16'd5, 16'd8, 15'd100);
    run_random(150);
    wait_drained();

    set_config(15'd0, 16'd0, 16'd0, 15'd0);
    run_random(150);
    wait_drained();

    set_config(15'h7FFF, 16'hFFFF, 16'hFFFF, 15'h7FFF);
    run_random(120);
    wait_drained();

    set_config(15'($urandom_range(1, 500)), 16'($urandom_range(1, 30)),
               16'($urandom_range(1, 30)), 15'($urandom_range(0, 2000)));
    run_random(80);
    wait_drained();
    run_random(80);
    wait_drained();

    set_config(15'($urandom_range(0, 32767)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), 15'($urandom_range(0, 32767)));
    run_random(150);
    wait_drained();

    // Receiver holds off while commands keep coming, so the input backs up.
    set_config(15'($urandom_range(1, 100)), 16'($urandom_range(1, 20)),
               16'($urandom_range(1, 20)), 15'($urandom_range(0, 500)));
    -> rx_hold_go;
    fast_mode = 1'b1;
    repeat (24) send_cmd(16'($urandom()));
    fast_mode = 1'b0;
    run_random(150);
    wait_drained();

    // Limits at the counter maximum: a held reversal with moving wheels keeps waiting.
    set_config(15'd0, 16'hFFFF, 16'hFFFF, 15'd0);
    fast_mode = 1'b1;
    send_cmd(16'd1);
    send_item(drg_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
    send_cmd(16'(-1));
    repeat (MAX_LIMIT_TICKS)
      send_item(drg_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF);
    fast_mode = 1'b0;
    wait_drained();

    if (sb.mismatches == 0) begin
      $display("tb_drive_reversal_gate_top passed");
    end else begin
      $display("tb_drive_reversal_gate_top failed");
    end
    $finish;
  end

endmodule

// File: drive_reversal_gate_top.f
sv/drg_pkg.sv
sv/drive_reversal_gate_top.sv
bench/tb_drive_reversal_gate_top.sv
